### rtl/lar_pkg.sv
// Package with shared types and constants for the light attenuation range block.
`default_nettype none
package lar_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CUTOFF_UNITS  = 10;
  localparam int RAD_W         = 70;
  localparam int SQ_STEPS      = RAD_W / 2;
  localparam int ROOT_W        = SQ_STEPS;
  localparam int SREM_W        = ROOT_W + 3;
  localparam int DEN_W         = 33;
  localparam int UN_W          = ROOT_W + 1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOT = 2'd1,
    ST_Q_ZERO  = 2'd2,
    ST_SAT     = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [31:0] l;
    logic [31:0]        qmag;
    logic               qneg;
    logic               neg;
    status_t            code;
  } ctx_t;

endpackage
`default_nettype wire

### rtl/lar_sqrt_cell.sv
// One digit step of the square root chain.
`default_nettype none
module lar_sqrt_cell
  import lar_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire logic [RAD_W-1:0]  in_rad,
  input  wire logic [SREM_W-1:0] in_rem,
  input  wire logic [ROOT_W-1:0] in_root,
  input  wire ctx_t              in_ctx,
  output logic                   out_valid,
  output logic [RAD_W-1:0]       out_rad,
  output logic [SREM_W-1:0]      out_rem,
  output logic [ROOT_W-1:0]      out_root,
  output ctx_t                   out_ctx
);

  logic [SREM_W-1:0] rem_sh;
  logic [SREM_W-1:0] trial;
  logic              take;

  always_comb begin
    rem_sh = {in_rem[SREM_W-3:0], in_rad[RAD_W-1 -: 2]};
    trial  = {1'b0, in_root, 2'b01};
    take   = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_rad  <= {in_rad[RAD_W-3:0], 2'b00};
      out_rem  <= take ? (rem_sh - trial) : rem_sh;
      out_root <= {in_root[ROOT_W-2:0], take};
      out_ctx  <= in_ctx;
    end
  end

endmodule
`default_nettype wire

### rtl/lar_div_cell.sv
// One quotient bit step of the restoring divider chain.
`default_nettype none
module lar_div_cell
  import lar_pkg::*;
#(
  parameter int NW = UN_W + FRAC_BITS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             in_valid,
  input  wire logic [NW-1:0]    in_num,
  input  wire logic [DEN_W-1:0] in_rem,
  input  wire logic [NW-1:0]    in_quo,
  input  wire ctx_t             in_ctx,
  output logic                  out_valid,
  output logic [NW-1:0]         out_num,
  output logic [DEN_W-1:0]      out_rem,
  output logic [NW-1:0]         out_quo,
  output ctx_t                  out_ctx
);

  logic [DEN_W:0] rem_sh;
  logic [DEN_W:0] den;
  logic           take;
  logic [DEN_W:0] diff;

  always_comb begin
    rem_sh = {in_rem, in_num[NW-1]};
    den    = {1'b0, in_ctx.qmag, 1'b0};
    take   = (rem_sh >= den);
    diff   = rem_sh - den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
    if (en) begin
      out_num <= {in_num[NW-2:0], 1'b0};
      out_rem <= take ? diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      out_quo <= {in_quo[NW-2:0], take};
      out_ctx <= in_ctx;
    end
  end

endmodule
`default_nettype wire

### rtl/light_attenuation_range.sv
// Throughput: one beat per cycle; the whole pipeline advances when the output is free.
// Stages: operand products, discriminant, 35 square root cells, numerator,
// one divider cell per quotient bit, saturation register.
// Reset clears all valid flags and loads the cutoff inverse with 10.0.
// Top level of the light attenuation range pipeline.
`default_nettype none
module light_attenuation_range
  import lar_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] constant_term,
  input  wire logic [31:0] linear_term,
  input  wire logic [31:0] quadratic_term,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      range_value,
  output logic [1:0]       status
);

  localparam int NW = UN_W + FRAC_BITS;
  localparam logic [31:0] CUTOFF_RST = 32'(CUTOFF_UNITS) << FRAC_BITS;

  logic        en;
  logic [31:0] cutoff;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cutoff <= CUTOFF_RST;
    end else if (cfg_we) begin
      cutoff <= cfg_wdata;
    end
  end

  // Operand stage.
  logic signed [33:0] cp;
  logic [32:0]        cp_mag;
  logic [31:0]        l_mag;
  logic [31:0]        q_mag;

  always_comb begin
    cp     = $signed({{2{constant_term[31]}}, constant_term}) - $signed({2'b00, cutoff});
    cp_mag = cp[33] ? 33'(-cp) : cp[32:0];
    l_mag  = linear_term[31] ? (32'd0 - linear_term) : linear_term;
    q_mag  = quadratic_term[31] ? (32'd0 - quadratic_term) : quadratic_term;
  end

  logic        a_valid;
  logic [63:0] a_l2;
  logic [64:0] a_p;
  logic        a_opp;
  ctx_t        a_ctx;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
    if (en) begin
      a_l2       <= l_mag * l_mag;
      a_p        <= q_mag * cp_mag;
      a_opp      <= quadratic_term[31] != cp[33];
      a_ctx.l    <= $signed(linear_term);
      a_ctx.qmag <= q_mag;
      a_ctx.qneg <= quadratic_term[31];
      a_ctx.neg  <= 1'b0;
      a_ctx.code <= (quadratic_term == 32'd0) ? ST_Q_ZERO : ST_OK;
    end
  end

  // Discriminant stage.
  logic [RAD_W-1:0] disc;
  logic [RAD_W-1:0] fl;
  logic [RAD_W-1:0] l2x;
  status_t          b_code;
  ctx_t             b_ctx;

  always_comb begin
    fl     = RAD_W'({a_p, 2'b00});
    l2x    = RAD_W'(a_l2);
    b_code = a_ctx.code;
    disc   = '0;
    if (a_p == '0 || a_opp) begin
      disc = l2x + fl;
    end else if (fl > l2x) begin
      if (b_code == ST_OK) begin
        b_code = ST_NO_ROOT;
      end
    end else begin
      disc = l2x - fl;
    end
    b_ctx      = a_ctx;
    b_ctx.code = b_code;
  end

  logic              sq_valid [0:SQ_STEPS];
  logic [RAD_W-1:0]  sq_rad   [0:SQ_STEPS];
  logic [SREM_W-1:0] sq_rem   [0:SQ_STEPS];
  logic [ROOT_W-1:0] sq_root  [0:SQ_STEPS];
  ctx_t              sq_ctx   [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_valid[0] <= 1'b0;
    end else if (en) begin
      sq_valid[0] <= a_valid;
    end
    if (en) begin
      sq_rad[0]  <= disc;
      sq_rem[0]  <= '0;
      sq_root[0] <= '0;
      sq_ctx[0]  <= b_ctx;
    end
  end

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
    lar_sqrt_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (sq_valid[i]),
      .in_rad    (sq_rad[i]),
      .in_rem    (sq_rem[i]),
      .in_root   (sq_root[i]),
      .in_ctx    (sq_ctx[i]),
      .out_valid (sq_valid[i+1]),
      .out_rad   (sq_rad[i+1]),
      .out_rem   (sq_rem[i+1]),
      .out_root  (sq_root[i+1]),
      .out_ctx   (sq_ctx[i+1])
    );
  end

  // Numerator stage.
  logic signed [UN_W:0] nval;
  logic [UN_W-1:0]      un;
  ctx_t                 n_ctx;

  always_comb begin
    if (sq_ctx[SQ_STEPS].qneg) begin
      nval = -(UN_W+1)'(sq_ctx[SQ_STEPS].l) - $signed({2'b00, sq_root[SQ_STEPS]});
    end else begin
      nval = -(UN_W+1)'(sq_ctx[SQ_STEPS].l) + $signed({2'b00, sq_root[SQ_STEPS]});
    end
    un        = nval[UN_W] ? UN_W'(-nval) : nval[UN_W-1:0];
    n_ctx     = sq_ctx[SQ_STEPS];
    n_ctx.neg = nval[UN_W] != sq_ctx[SQ_STEPS].qneg;
  end

  logic             dv_valid [0:NW];
  logic [NW-1:0]    dv_num   [0:NW];
  logic [DEN_W-1:0] dv_rem   [0:NW];
  logic [NW-1:0]    dv_quo   [0:NW];
  ctx_t             dv_ctx   [0:NW];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_valid[0] <= 1'b0;
    end else if (en) begin
      dv_valid[0] <= sq_valid[SQ_STEPS];
    end
    if (en) begin
      dv_num[0] <= {un, {FRAC_BITS{1'b0}}};
      dv_rem[0] <= '0;
      dv_quo[0] <= '0;
      dv_ctx[0] <= n_ctx;
    end
  end

  for (genvar j = 0; j < NW; j++) begin : g_div
    lar_div_cell #(.NW(NW)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (dv_valid[j]),
      .in_num    (dv_num[j]),
      .in_rem    (dv_rem[j]),
      .in_quo    (dv_quo[j]),
      .in_ctx    (dv_ctx[j]),
      .out_valid (dv_valid[j+1]),
      .out_num   (dv_num[j+1]),
      .out_rem   (dv_rem[j+1]),
      .out_quo   (dv_quo[j+1]),
      .out_ctx   (dv_ctx[j+1])
    );
  end

  // Saturation and output register.
  logic [NW-1:0] quo;
  logic [31:0]   res;
  status_t       code;

  always_comb begin
    quo  = dv_quo[NW];
    code = dv_ctx[NW].code;
    res  = '0;
    if (code == ST_OK) begin
      if (!dv_ctx[NW].neg) begin
        if (quo > NW'(32'h7FFF_FFFF)) begin
          res  = 32'h7FFF_FFFF;
          code = ST_SAT;
        end else begin
          res = quo[31:0];
        end
      end else begin
        if (quo > NW'(32'h8000_0000)) begin
          res  = 32'h8000_0000;
          code = ST_SAT;
        end else begin
          res = 32'd0 - quo[31:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid[NW];
    end
    if (en) begin
      range_value <= res;
      status      <= code;
    end
  end

endmodule
`default_nettype wire

### rtl/lar_checker.sv
// Port-level checker for the light attenuation range block, with its bind.
`default_nettype none
module lar_checker
  import lar_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [31:0] range_value,
  input wire logic [1:0]  status
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(range_value) && $stable(status))
    else $error("output beat changed while stalled");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst) !out_valid |-> in_ready)
    else $error("input stalled with an empty output");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_NO_ROOT || status == ST_Q_ZERO) |-> range_value == 32'd0)
    else $error("nonzero range on a failed solve");

endmodule

bind light_attenuation_range lar_checker u_lar_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .range_value (range_value),
  .status      (status)
);
`default_nettype wire

### test/tb_light_attenuation_range.sv
// Self-checking testbench for the light attenuation range pipeline.
module tb_light_attenuation_range;
  import lar_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam int LATENCY = 39 + FB + 36;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic [31:0] c;
    logic [31:0] l;
    logic [31:0] q;
  } light_t;

  typedef struct packed {
    logic [31:0] rng;
    status_t     st;
  } range_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] constant_term = '0, linear_term = '0, quadratic_term = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [31:0] range_value;
  logic [1:0] status;

  light_attenuation_range dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .constant_term(constant_term), .linear_term(linear_term),
    .quadratic_term(quadratic_term),
    .out_valid(out_valid), .out_ready(out_ready),
    .range_value(range_value), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  light_t pending_lights[$];
  range_t expected_ranges[$];
  logic [31:0] cutoff_inv;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_recv = 0;
  int sent = 0, received = 0, idle_cycles = 0;
  int st_seen[4];
  logic accepted_in = 1'b0;

  function automatic logic [34:0] floor_sqrt(logic [69:0] d);
    logic [34:0] r;
    logic [34:0] cand;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      cand = r | (35'd1 << b);
      if ({70'd0, cand} * {70'd0, cand} <= {70'd0, d}) r = cand;
    end
    return r;
  endfunction

  function automatic range_t solve_range(light_t lt, logic [31:0] cinv);
    range_t res;
    logic signed [35:0] c, l, q, cp;
    logic signed [71:0] disc;
    logic signed [71:0] n;
    logic [71:0] un, qmag, quo;
    logic neg;
    c = $signed(lt.c);
    l = $signed(lt.l);
    q = $signed(lt.q);
    cp = c - $signed({4'd0, cinv});
    res.rng = '0;
    res.st = ST_OK;
    if (q == 0) begin
      res.st = ST_Q_ZERO;
      return res;
    end
    disc = 72'(l) * 72'(l) - 72'sd4 * 72'(q) * 72'(cp);
    if (disc < 0) begin
      res.st = ST_NO_ROOT;
      return res;
    end
    n = (q > 0) ? (-72'(l) + $signed({37'd0, floor_sqrt(disc[69:0])}))
                : (-72'(l) - $signed({37'd0, floor_sqrt(disc[69:0])}));
    un = (n < 0) ? 72'(-n) : 72'(n);
    qmag = (q < 0) ? 72'(-q) : 72'(q);
    quo = (un << FB) / (qmag << 1);
    neg = (n < 0) != (q < 0);
    if (!neg) begin
      if (quo > 72'h7FFFFFFF) begin
        res.rng = 32'h7FFFFFFF;
        res.st = ST_SAT;
      end else begin
        res.rng = quo[31:0];
      end
    end else begin
      if (quo > 72'h80000000) begin
        res.rng = 32'h80000000;
        res.st = ST_SAT;
      end else begin
        res.rng = 32'(-quo);
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, received);
    errors++;
  endtask

  // Driver: offers the next queued light and drives out_ready at the falling edge.
  always @(negedge clk) begin
    if (!rst) begin
      if (!in_valid || accepted_in) begin
        if (pending_lights.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {constant_term, linear_term, quadratic_term} <= pending_lights.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      if (hold_recv > 0) begin
        out_ready <= 1'b0;
        hold_recv <= hold_recv - 1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Monitor: samples both handshakes and runs the idle watchdog at the rising edge.
  always @(posedge clk) begin
    accepted_in <= 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_ranges.push_back(solve_range({constant_term, linear_term, quadratic_term},
                                              cutoff_inv));
        accepted_in <= 1'b1;
        sent++;
      end
      if (out_valid && out_ready) begin
        received++;
        if (expected_ranges.size() == 0) begin
          report_mismatch("unexpected beat", range_value, '0);
        end else begin
          range_t e;
          e = expected_ranges.pop_front();
          if (range_value !== e.rng) report_mismatch("range_value", range_value, e.rng);
          if (status !== e.st) report_mismatch("status", {30'd0, status}, {30'd0, e.st});
          st_seen[e.st]++;
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
        $display("Watchdog expired with %0d beats outstanding", expected_ranges.size());
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return 32'h80000000;
      1: return 32'h7FFFFFFF;
      2: return 32'($urandom_range(8)) << $urandom_range(31);
      3: return -(32'($urandom_range(8)) << $urandom_range(20));
      default: return $urandom();
    endcase
  endfunction

  function automatic light_t rand_light();
    light_t lt;
    int shape;
    shape = $urandom_range(9);
    lt.c = rand_word();
    lt.l = rand_word();
    lt.q = rand_word();
    if (shape < 5) begin
      lt.c = 32'(1 << 16) + ($urandom() & 32'h0001FFFF);
      lt.l = $urandom() >> $urandom_range(31);
      lt.q = ($urandom() >> $urandom_range(31)) | 32'd1;
      if (shape == 0) lt.q = -lt.q;
    end else if (shape == 5) begin
      lt.q = '0;
    end
    return lt;
  endfunction

  task automatic drain();
    while (pending_lights.size() > 0 || in_valid || expected_ranges.size() > 0)
      @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_cutoff(logic [31:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cutoff_inv = v;
  endtask

  initial begin
    cutoff_inv = 32'(CUTOFF_UNITS) << FB;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    pending_lights.push_back('{32'h000B0000, 32'h00020000, 32'h00010000});
    pending_lights.push_back('{32'h000A0000, 32'h0, 32'h00010000});
    pending_lights.push_back('{32'h000A0000, 32'h00040000, 32'h00010000});
    pending_lights.push_back('{32'h00140000, 32'h0, 32'h00010000});
    pending_lights.push_back('{32'h00010000, 32'h00010000, 32'h0});
    pending_lights.push_back('{32'h0, 32'h0, 32'h00000001});
    pending_lights.push_back('{32'h0, 32'h0, 32'hFFFFFFFF});
    pending_lights.push_back('{32'h80000000, 32'h80000000, 32'h80000000});
    pending_lights.push_back('{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF});
    pending_lights.push_back('{32'h80000000, 32'h7FFFFFFF, 32'h00000001});
    pending_lights.push_back('{32'h7FFFFFFF, 32'h80000000, 32'h80000000});
    pending_lights.push_back('{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF});
    pending_lights.push_back('{32'h0, 32'h7FFFFFFF, 32'hFFFFFFFF});
    pending_lights.push_back('{32'h0, 32'h80000000, 32'h00000001});
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_cutoff(32'd0);
        1: set_cutoff(32'hFFFFFFFF);
        2: set_cutoff($urandom());
        3: set_cutoff(32'h00010000);
        default: set_cutoff(32'(CUTOFF_UNITS) << FB);
      endcase
      send_idle_pct = (ph == 1 || ph == 3) ? 68 : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? 68 : 0;
      if (ph == 4) send_idle_pct = 32;
      if (ph == 4) recv_stall_pct = 32;
      if (ph == 5) hold_recv = 400;
      for (int i = 0; i < 140; i++) pending_lights.push_back(rand_light());
      if (ph == 5) begin
        while (pending_lights.size() > 70) @(posedge clk);
        while (in_valid || expected_ranges.size() > 0) @(posedge clk);
        for (int i = 0; i < 20; i++) pending_lights.push_back(rand_light());
      end
      drain();
    end

    $display("Sent %0d lights, checked %0d ranges; six cutoff settings with idle and stalls.",
             sent, received);
    $display("Status counts ok/no-root/q-zero/sat: %0d %0d %0d %0d",
             st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
    if (errors == 0 && expected_ranges.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
